@@ design/sts_pkg.sv @@
`default_nettype none
package sts_pkg;

  localparam int unsigned MaxRes = 3;

  localparam logic [6:0] KEof    = 7'd0;
  localparam logic [6:0] KError  = 7'd1;
  localparam logic [6:0] KIdent  = 7'd2;
  localparam logic [6:0] KInt    = 7'd3;
  localparam logic [6:0] KFloat  = 7'd4;
  localparam logic [6:0] KDouble = 7'd5;
  localparam logic [6:0] KStrLit = 7'd6;
  localparam logic [6:0] KKw0    = 7'd7;
  localparam logic [6:0] KDot    = 7'd41;
  localparam logic [6:0] KSlash  = 7'd47;
  localparam logic [6:0] KNone   = 7'd127;

  localparam int unsigned NumKw = 27;
  localparam int unsigned KwLen = 7;

  typedef logic [8*KwLen-1:0] kw_text_t;

  typedef enum logic [11:0] {
    MIdle  = 12'b000000000001,
    MSlash = 12'b000000000010,
    MLine  = 12'b000000000100,
    MBlock = 12'b000000001000,
    MBstar = 12'b000000010000,
    MIdent = 12'b000000100000,
    MInt   = 12'b000001000000,
    MDot   = 12'b000010000000,
    MFrac  = 12'b000100000000,
    MStr   = 12'b001000000000,
    MEsc   = 12'b010000000000,
    MOp    = 12'b100000000000
  } mode_e;

  // Keywords are stored first byte in the low byte, padded with zeros.
  function automatic kw_text_t kw_text(input int unsigned i);
    kw_text_t t;
    t = '0;
    case (i)
      0:  t = {8'h00,8'h00,8'h00,8'h00,8'h00,"n","f"};
      1:  t = {8'h00,"t","c","u","r","t","s"};
      2:  t = {8'h00,8'h00,"t","i","a","r","t"};
      3:  t = {8'h00,8'h00,8'h00,"l","p","m","i"};
      4:  t = {8'h00,8'h00,"o","r","c","a","m"};
      5:  t = {8'h00,8'h00,8'h00,8'h00,"e","s","u"};
      6:  t = {8'h00,8'h00,"t","s","n","o","c"};
      7:  t = {8'h00,8'h00,8'h00,8'h00,"t","e","l"};
      8:  t = {8'h00,8'h00,8'h00,8'h00,"t","u","m"};
      9:  t = {8'h00,8'h00,8'h00,8'h00,"b","u","p"};
      10: t = {8'h00,8'h00,8'h00,8'h00,8'h00,"f","i"};
      11: t = {8'h00,8'h00,8'h00,"e","s","l","e"};
      12: t = {8'h00,8'h00,8'h00,8'h00,"r","o","f"};
      13: t = {8'h00,8'h00,8'h00,8'h00,8'h00,"n","i"};
      14: t = {8'h00,8'h00,"h","c","t","a","m"};
      15: t = {8'h00,"n","r","u","t","e","r"};
      16: t = {8'h00,8'h00,8'h00,8'h00,"y","r","t"};
      17: t = {8'h00,8'h00,"h","c","t","a","c"};
      18: t = {"y","l","l","a","n","i","f"};
      19: t = {8'h00,8'h00,8'h00,"e","u","r","t"};
      20: t = {8'h00,8'h00,"e","s","l","a","f"};
      21: t = {8'h00,8'h00,8'h00,"e","n","o","N"};
      22: t = {8'h00,8'h00,8'h00,8'h00,"t","n","i"};
      23: t = {8'h00,8'h00,"t","a","o","l","f"};
      24: t = {8'h00,"e","l","b","u","o","d"};
      25: t = {8'h00,8'h00,8'h00,"l","o","o","b"};
      26: t = {8'h00,"g","n","i","r","t","s"};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input int unsigned i);
    logic [2:0] l;
    l = 3'd0;
    case (i)
      0, 10, 13: l = 3'd2;
      5, 7, 8, 9, 12, 16, 22: l = 3'd3;
      3, 11, 19, 21, 25: l = 3'd4;
      2, 4, 6, 14, 17, 20, 23: l = 3'd5;
      1, 15, 24, 26: l = 3'd6;
      18: l = 3'd7;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic [6:0] kind_one(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      "(": k = 7'd34;
      ")": k = 7'd35;
      "{": k = 7'd36;
      "}": k = 7'd37;
      "[": k = 7'd38;
      "]": k = 7'd39;
      ",": k = 7'd40;
      ".": k = 7'd41;
      ":": k = 7'd42;
      ";": k = 7'd43;
      "+": k = 7'd44;
      "-": k = 7'd45;
      "*": k = 7'd46;
      "/": k = 7'd47;
      "%": k = 7'd48;
      "!": k = 7'd49;
      "&": k = 7'd50;
      "|": k = 7'd51;
      "<": k = 7'd52;
      ">": k = 7'd53;
      "=": k = 7'd54;
      "$": k = 7'd65;
      default: k = KNone;
    endcase
    return k;
  endfunction

  function automatic logic needs_look(input logic [7:0] c);
    return c == "." || c == ":" || c == "-" || c == "!" || c == "=" ||
           c == "<" || c == ">" || c == "&" || c == "|";
  endfunction

  function automatic logic [6:0] kind_two(input logic [7:0] p, input logic [7:0] c);
    logic [6:0] k;
    k = KNone;
    if (p == "." && c == ".") k = 7'd58;
    if (p == ":" && c == ":") k = 7'd57;
    if (p == "-" && c == ">") k = 7'd55;
    if (p == "!" && c == "=") k = 7'd60;
    if (p == "=" && c == "=") k = 7'd59;
    if (p == "=" && c == ">") k = 7'd56;
    if (p == "<" && c == "=") k = 7'd61;
    if (p == ">" && c == "=") k = 7'd62;
    if (p == "&" && c == "&") k = 7'd63;
    if (p == "|" && c == "|") k = 7'd64;
    return k;
  endfunction

  typedef struct packed {
    logic [6:0] kind;
    logic [1:0] len_sel;
  } tok_desc_t;

  typedef struct packed {
    logic [1:0] n;
    tok_desc_t [MaxRes-1:0] tok;
  } fe_msg_t;

endpackage
`default_nettype wire

@@ design/source_token_scanner.sv @@
`default_nettype none
// Channel  Signals                                              Direction
// in       in_valid_i in_ready_o op_i byte_in_i                 into block
// out      out_valid_o out_ready_i kind_o start_offset_o
//          token_length_o line_no_o col_no_o last_o             out of block
// One byte is taken each cycle; the front end decides its tokens in that cycle.
// Tokens leave one per cycle while out_ready_i is high, from a two-beat queue;
// a byte giving three tokens sends them in turn. Input stalls only when the
// queue is full. Reset returns the scanner to the start of a fresh source.
module source_token_scanner #(
  parameter int unsigned KEYWORD_MAX_LEN = 7,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  byte_in_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [6:0]  kind_o,
  output      logic [31:0] start_offset_o,
  output      logic [31:0] token_length_o,
  output      logic [31:0] line_no_o,
  output      logic [31:0] col_no_o,
  output      logic        last_o
);
  logic q_ready, q_push;
  logic [1:0] q_n;
  logic [3*(7+4*COUNT_WIDTH)-1:0] q_data;

  sts_core #(.KeywordMaxLen(KEYWORD_MAX_LEN), .CountWidth(COUNT_WIDTH)) u_core (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .byte_in_i,
    .q_ready_i(q_ready), .q_push_o(q_push), .q_n_o(q_n), .q_data_o(q_data)
  );

  sts_out #(.CountWidth(COUNT_WIDTH)) u_out (
    .clk_i, .rst_ni, .push_i(q_push), .n_i(q_n), .data_i(q_data),
    .ready_o(q_ready), .out_valid_o, .out_ready_i, .kind_o, .start_offset_o,
    .token_length_o, .line_no_o, .col_no_o, .last_o
  );
endmodule
`default_nettype wire

@@ design/sts_core.sv @@
`default_nettype none
// Scanner front end: one beat per cycle unless stalled. It classifies each byte, updates
// the scan state and counters, and writes a beat of up to three finished tokens.
module sts_core #(
  parameter int unsigned KeywordMaxLen = 7,
  parameter int unsigned CountWidth = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic                  op_i,
  input  wire logic [7:0]            byte_in_i,
  input  wire logic                  q_ready_i,
  output      logic                  q_push_o,
  output      logic [1:0]            q_n_o,
  output      logic [3*(7+4*CountWidth)-1:0] q_data_o
);
  localparam int unsigned CW = CountWidth;
  localparam int unsigned TW = 7 + 4*CW;
  localparam int unsigned BW = $clog2(KeywordMaxLen);
  localparam logic [CW-1:0] CMax = '1;

  sts_pkg::mode_e mode_q, mode_d;
  logic [7:0] pend_q, pend_d;
  logic [7:0] wbuf_q [KeywordMaxLen];
  logic [CW-1:0] wc_q, wc_d, off_q, off_d, line_q, line_d, col_q, col_d;
  logic [CW-1:0] ts_q, ts_d, tl_q, tl_d, tc_q, tc_d;
  logic halted_q, halted_d;
  logic wb_we;
  logic [BW-1:0] wb_addr;

  function automatic logic [CW-1:0] sat(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? CMax : s[CW-1:0];
  endfunction

  logic [6:0] wkind;
  always_comb begin
    logic hit;
    sts_pkg::kw_text_t txt;
    wkind = sts_pkg::KIdent;
    for (int i = 0; i < sts_pkg::NumKw; i++) begin
      hit = (wc_q == CW'(sts_pkg::kw_len(i)));
      txt = sts_pkg::kw_text(i);
      for (int j = 0; j < sts_pkg::KwLen; j++) begin
        if (j < int'(sts_pkg::kw_len(i)) && j < KeywordMaxLen) begin
          if (wbuf_q[j] != txt[8*j +: 8]) hit = 1'b0;
        end
      end
      if (hit && wkind == sts_pkg::KIdent) wkind = sts_pkg::KKw0 + 7'(i);
    end
  end

  logic [TW-1:0] toks [3];
  logic [1:0] n;
  logic c_end;
  logic [7:0] c;

  assign in_ready_o = q_ready_i;
  wire fire = in_valid_i && in_ready_o;
  assign c = byte_in_i;
  assign c_end = op_i || (byte_in_i == 8'd0);

  always_comb begin
    logic absorbed, err;
    logic [6:0] k;
    logic [CW-1:0] ts, tl, tc, wc;
    mode_d = mode_q; pend_d = pend_q; wc_d = wc_q; off_d = off_q;
    line_d = line_q; col_d = col_q; ts_d = ts_q; tl_d = tl_q; tc_d = tc_q;
    halted_d = halted_q; wb_we = 1'b0; wb_addr = '0;
    n = 2'd0; absorbed = 1'b0; err = 1'b0; k = '0;
    for (int i = 0; i < 3; i++) begin
      toks[i] = '0;
    end
    ts = ts_q; tl = tl_q; tc = tc_q; wc = wc_q;
    if (c_end) begin
      if (!halted_q) begin
        case (mode_q)
          sts_pkg::MSlash: begin
            toks[n] = {sts_pkg::KSlash, ts, wc, tl, tc}; n = n + 2'd1;
          end
          sts_pkg::MIdent: begin
            toks[n] = {wkind, ts, wc, tl, tc}; n = n + 2'd1;
          end
          sts_pkg::MInt: begin
            toks[n] = {sts_pkg::KInt, ts, wc, tl, tc}; n = n + 2'd1;
          end
          sts_pkg::MDot: begin
            toks[n] = {sts_pkg::KInt, ts, wc, tl, tc}; n = n + 2'd1;
            toks[n] = {sts_pkg::KDot, sat(ts, wc), CW'(1), tl, sat(tc, wc)};
            n = n + 2'd1;
          end
          sts_pkg::MFrac: begin
            toks[n] = {sts_pkg::KDouble, ts, wc, tl, tc}; n = n + 2'd1;
          end
          sts_pkg::MOp: begin
            k = sts_pkg::kind_one(pend_q);
            if (k == sts_pkg::KNone) k = sts_pkg::KError;
            toks[n] = {k, ts, wc, tl, tc}; n = n + 2'd1;
          end
          sts_pkg::MStr, sts_pkg::MEsc: begin
            toks[n] = {sts_pkg::KError, ts, wc, tl, tc}; n = n + 2'd1; err = 1'b1;
          end
          default: ;
        endcase
        if (!err) begin
          toks[n] = {sts_pkg::KEof, off_q, CW'(0), line_q, col_q}; n = n + 2'd1;
        end
      end
      mode_d = sts_pkg::MIdle; pend_d = '0; wc_d = '0; off_d = '0;
      line_d = CW'(1); col_d = CW'(1); ts_d = '0; tl_d = CW'(1); tc_d = CW'(1);
      halted_d = 1'b0;
    end else if (!halted_q) begin
      if (mode_q == sts_pkg::MDot) begin
        if (sts_pkg::is_digit(c)) begin
          wc = sat(wc, CW'(2)); mode_d = sts_pkg::MFrac; absorbed = 1'b1;
        end else begin
          toks[n] = {sts_pkg::KInt, ts, wc, tl, tc}; n = n + 2'd1;
          ts = sat(ts, wc); tc = sat(tc, wc); wc = CW'(1);
          mode_d = sts_pkg::MOp; pend_d = ".";
        end
      end
      if (!absorbed) begin
        case (mode_d)
          sts_pkg::MSlash: begin
            if (c == "/") begin mode_d = sts_pkg::MLine; absorbed = 1'b1; end
            else if (c == "*") begin mode_d = sts_pkg::MBlock; absorbed = 1'b1; end
            else begin
              toks[n] = {sts_pkg::KSlash, ts, wc, tl, tc}; n = n + 2'd1;
              mode_d = sts_pkg::MIdle;
            end
          end
          sts_pkg::MLine: begin
            if (c == 8'h0a) mode_d = sts_pkg::MIdle;
            absorbed = 1'b1;
          end
          sts_pkg::MBlock: begin
            if (c == "*") mode_d = sts_pkg::MBstar;
            absorbed = 1'b1;
          end
          sts_pkg::MBstar: begin
            if (c == "/") mode_d = sts_pkg::MIdle;
            else if (c != "*") mode_d = sts_pkg::MBlock;
            absorbed = 1'b1;
          end
          sts_pkg::MIdent: begin
            if (sts_pkg::is_word(c)) begin
              if (wc < CW'(KeywordMaxLen)) begin
                wb_we = 1'b1; wb_addr = wc[BW-1:0];
              end
              wc = sat(wc, CW'(1)); absorbed = 1'b1;
            end else begin
              toks[n] = {wkind, ts, wc, tl, tc}; n = n + 2'd1;
              mode_d = sts_pkg::MIdle;
            end
          end
          sts_pkg::MInt: begin
            if (sts_pkg::is_digit(c)) begin wc = sat(wc, CW'(1)); absorbed = 1'b1; end
            else if (c == ".") begin mode_d = sts_pkg::MDot; absorbed = 1'b1; end
            else begin
              toks[n] = {sts_pkg::KInt, ts, wc, tl, tc}; n = n + 2'd1;
              mode_d = sts_pkg::MIdle;
            end
          end
          sts_pkg::MFrac: begin
            if (sts_pkg::is_digit(c)) begin
              wc = sat(wc, CW'(1)); absorbed = 1'b1;
            end else if (c == "f") begin
              wc = sat(wc, CW'(1));
              toks[n] = {sts_pkg::KFloat, ts, wc, tl, tc}; n = n + 2'd1;
              mode_d = sts_pkg::MIdle; absorbed = 1'b1;
            end else begin
              toks[n] = {sts_pkg::KDouble, ts, wc, tl, tc}; n = n + 2'd1;
              mode_d = sts_pkg::MIdle;
            end
          end
          sts_pkg::MStr: begin
            wc = sat(wc, CW'(1));
            if (c == "\\") mode_d = sts_pkg::MEsc;
            else if (c == "\"") begin
              toks[n] = {sts_pkg::KStrLit, ts, wc, tl, tc}; n = n + 2'd1;
              mode_d = sts_pkg::MIdle;
            end
            absorbed = 1'b1;
          end
          sts_pkg::MEsc: begin
            wc = sat(wc, CW'(1)); mode_d = sts_pkg::MStr; absorbed = 1'b1;
          end
          sts_pkg::MOp: begin
            k = sts_pkg::kind_two(pend_d, c);
            if (k != sts_pkg::KNone) begin
              toks[n] = {k, ts, CW'(2), tl, tc}; n = n + 2'd1;
              wc = CW'(2); absorbed = 1'b1;
            end else begin
              k = sts_pkg::kind_one(pend_d);
              if (k == sts_pkg::KNone) k = sts_pkg::KError;
              toks[n] = {k, ts, wc, tl, tc}; n = n + 2'd1;
            end
            mode_d = sts_pkg::MIdle;
          end
          default: ;
        endcase
      end
      if (mode_d == sts_pkg::MIdle) pend_d = '0;
      if (!absorbed) begin
        ts = off_q; tl = line_q; tc = col_q; wc = CW'(1);
        if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
        end else if (c == "/") mode_d = sts_pkg::MSlash;
        else if (sts_pkg::is_alpha(c) || c == "_") begin
          wb_we = 1'b1; wb_addr = '0; mode_d = sts_pkg::MIdent;
        end else if (sts_pkg::is_digit(c)) mode_d = sts_pkg::MInt;
        else if (c == "\"") mode_d = sts_pkg::MStr;
        else if (sts_pkg::needs_look(c)) begin
          mode_d = sts_pkg::MOp; pend_d = c;
        end else begin
          k = sts_pkg::kind_one(c);
          if (k == sts_pkg::KNone) begin k = sts_pkg::KError; halted_d = 1'b1; end
          toks[n] = {k, ts, wc, tl, tc}; n = n + 2'd1;
        end
      end
      ts_d = ts; tl_d = tl; tc_d = tc; wc_d = wc;
      off_d = sat(off_q, CW'(1));
      if (c == 8'h0a) begin line_d = sat(line_q, CW'(1)); col_d = CW'(1); end
      else col_d = sat(col_q, CW'(1));
    end
  end

  assign q_push_o = fire && (n != 2'd0);
  assign q_n_o = n;
  assign q_data_o = {toks[2], toks[1], toks[0]};

  always_ff @(posedge clk_i) begin
    if (fire && wb_we) wbuf_q[wb_addr] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sts_pkg::MIdle; pend_q <= '0; wc_q <= '0; off_q <= '0;
      line_q <= CW'(1); col_q <= CW'(1); ts_q <= '0; tl_q <= CW'(1);
      tc_q <= CW'(1); halted_q <= 1'b0;
    end else if (fire) begin
      mode_q <= mode_d; pend_q <= pend_d; wc_q <= wc_d; off_q <= off_d;
      line_q <= line_d; col_q <= col_d; ts_q <= ts_d; tl_q <= tl_d;
      tc_q <= tc_d; halted_q <= halted_d;
    end
  end
endmodule
`default_nettype wire

@@ design/sts_out.sv @@
`default_nettype none
// Back end: a two-entry queue of token beats, drained one token per cycle while out_ready_i is high.
module sts_out #(
  parameter int unsigned CountWidth = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic [1:0]            n_i,
  input  wire logic [3*(7+4*CountWidth)-1:0] data_i,
  output      logic                  ready_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [6:0]            kind_o,
  output      logic [31:0]           start_offset_o,
  output      logic [31:0]           token_length_o,
  output      logic [31:0]           line_no_o,
  output      logic [31:0]           col_no_o,
  output      logic                  last_o
);
  localparam int unsigned CW = CountWidth;
  localparam int unsigned TW = 7 + 4*CW;

  logic [3*TW-1:0] data_q [2];
  logic [1:0] num_q [2];
  logic [1:0] idx_q;
  logic rd_q, wr_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);

  logic [TW-1:0] t;
  assign t = data_q[rd_q][idx_q*TW +: TW];
  logic [CW-1:0] f_off, f_len, f_line, f_col;
  assign {kind_o, f_off, f_len, f_line, f_col} = t;
  assign start_offset_o = 32'(f_off);
  assign token_length_o = 32'(f_len);
  assign line_no_o = 32'(f_line);
  assign col_no_o = 32'(f_col);
  assign last_o = (idx_q + 2'd1 == num_q[rd_q]);

  wire pop = out_valid_o && out_ready_i && last_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_q] <= data_i;
      num_q[wr_q] <= n_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (out_valid_o && out_ready_i) begin
        if (last_o) begin idx_q <= '0; rd_q <= ~rd_q; end
        else idx_q <= idx_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ sim/source_token_scanner_test.sv @@
`timescale 1ns / 1ps

module source_token_scanner_test;

  localparam int unsigned WatchLimit = 5000;
  localparam logic [6:0] KOneBase = 7'd34;
  localparam logic [6:0] KTwoBase = 7'd55;
  localparam logic [6:0] KDollar = 7'd65;
  localparam bit OpByte = 1'b0;
  localparam bit OpEnd = 1'b1;

  typedef struct packed {
    logic [6:0] kind;
    logic [31:0] off;
    logic [31:0] len;
    logic [31:0] line;
    logic [31:0] col;
    logic last;
  } token_t;

  string kw_names[27] = '{"fn", "struct", "trait", "impl", "macro", "use", "const", "let",
    "mut", "pub", "if", "else", "for", "in", "match", "return", "try", "catch", "finally",
    "true", "false", "None", "int", "float", "double", "bool", "string"};
  string one_ops = "(){}[],.:;+-*/%!&|<>=";
  string two_ops[10] = '{"->", "=>", "::", "..", "==", "!=", "<=", ">=", "&&", "||"};
  string frag_ops[16] = '{"(", ")", "{", "}", ",", ";", "+", "*", "%", "$", "->", "::", "==",
    "<=", "&&", "|"};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic op_i = 1'b0;
  logic [7:0] byte_in_i = 8'd0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic [6:0] kind_o;
  logic [31:0] start_offset_o, token_length_o, line_no_o, col_no_o;
  logic last_o;

  token_t token_q[$];
  int unsigned errors = 0;
  int unsigned tokens_checked = 0;
  int unsigned sources_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  sts_pkg::mode_e scan_md;
  logic [7:0] pend_byte;
  logic [7:0] word_buf[7];
  logic [31:0] word_cnt, byte_off, cur_line, cur_col, tok_off, tok_line, tok_col;
  logic halted;
  int emitted;

  source_token_scanner dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .op_i(op_i), .byte_in_i(byte_in_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .kind_o(kind_o), .start_offset_o(start_offset_o), .token_length_o(token_length_o),
    .line_no_o(line_no_o), .col_no_o(col_no_o), .last_o(last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [6:0] single_kind(logic [7:0] c);
    if (c == "$") return KDollar;
    for (int i = 0; i < one_ops.len(); i++) if (one_ops[i] == c) return KOneBase + 7'(i);
    return sts_pkg::KNone;
  endfunction

  function automatic logic [6:0] pair_kind(logic [7:0] p, logic [7:0] c);
    for (int i = 0; i < 10; i++) begin
      if (two_ops[i][0] == p && two_ops[i][1] == c) return KTwoBase + 7'(i);
    end
    return sts_pkg::KNone;
  endfunction

  function automatic bit lookahead_c(logic [7:0] c);
    return c == "." || c == ":" || c == "-" || c == "!" || c == "=" || c == "<" ||
           c == ">" || c == "&" || c == "|";
  endfunction

  function automatic logic [6:0] word_kind();
    bit hit;
    if (word_cnt > 7) return sts_pkg::KIdent;
    for (int i = 0; i < 27; i++) begin
      if (kw_names[i].len() == word_cnt) begin
        hit = 1'b1;
        for (int j = 0; j < kw_names[i].len(); j++) if (kw_names[i][j] != word_buf[j]) hit = 0;
        if (hit) return sts_pkg::KKw0 + 7'(i);
      end
    end
    return sts_pkg::KIdent;
  endfunction

  function automatic void clear_scanner();
    scan_md = sts_pkg::MIdle;
    pend_byte = 8'd0;
    word_cnt = 0;
    byte_off = 0;
    cur_line = 1;
    cur_col = 1;
    tok_off = 0;
    tok_line = 1;
    tok_col = 1;
    halted = 1'b0;
  endfunction

  function automatic void push_token(logic [6:0] k, logic [31:0] o, logic [31:0] l,
                                     logic [31:0] ln, logic [31:0] cl);
    token_t t;
    if (emitted >= 3) return;
    t = '{kind: k, off: o, len: l, line: ln, col: cl, last: 1'b0};
    token_q.push_back(t);
    emitted++;
  endfunction

  function automatic void push_current(logic [6:0] k);
    push_token(k, tok_off, word_cnt, tok_line, tok_col);
  endfunction

  function automatic void split_number_dot();
    push_current(sts_pkg::KInt);
    tok_off = sat_inc(tok_off, word_cnt);
    tok_col = sat_inc(tok_col, word_cnt);
    word_cnt = 1;
    scan_md = sts_pkg::MOp;
    pend_byte = ".";
  endfunction

  function automatic void begin_token(logic [7:0] c);
    logic [6:0] k;
    tok_off = byte_off;
    tok_line = cur_line;
    tok_col = cur_col;
    word_cnt = 1;
    if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) return;
    if (c == "/") begin
      scan_md = sts_pkg::MSlash;
    end else if (alpha_c(c) || c == "_") begin
      word_buf[0] = c;
      scan_md = sts_pkg::MIdent;
    end else if (digit_c(c)) begin
      scan_md = sts_pkg::MInt;
    end else if (c == "\"") begin
      scan_md = sts_pkg::MStr;
    end else if (lookahead_c(c)) begin
      scan_md = sts_pkg::MOp;
      pend_byte = c;
    end else begin
      k = single_kind(c);
      if (k != sts_pkg::KNone) begin
        push_current(k);
      end else begin
        push_current(sts_pkg::KError);
        halted = 1'b1;
      end
    end
  endfunction

  function automatic void predict_tokens(bit op, logic [7:0] c);
    bit taken;
    bit open_str;
    logic [6:0] k;
    emitted = 0;
    taken = 1'b0;
    if (op || c == 8'd0) begin
      open_str = 1'b0;
      if (halted) begin
        clear_scanner();
        return;
      end
      case (scan_md)
        sts_pkg::MSlash: push_current(sts_pkg::KSlash);
        sts_pkg::MIdent: push_current(word_kind());
        sts_pkg::MInt: push_current(sts_pkg::KInt);
        sts_pkg::MDot: begin
          split_number_dot();
          push_current(sts_pkg::KDot);
        end
        sts_pkg::MFrac: push_current(sts_pkg::KDouble);
        sts_pkg::MOp: begin
          k = single_kind(pend_byte);
          push_current(k != sts_pkg::KNone ? k : sts_pkg::KError);
        end
        sts_pkg::MStr, sts_pkg::MEsc: begin
          push_current(sts_pkg::KError);
          open_str = 1'b1;
        end
        default: ;
      endcase
      if (!open_str) push_token(sts_pkg::KEof, byte_off, 0, cur_line, cur_col);
      clear_scanner();
    end else begin
      if (halted) return;
      if (scan_md == sts_pkg::MDot) begin
        if (digit_c(c)) begin
          word_cnt = sat_inc(word_cnt, 2);
          scan_md = sts_pkg::MFrac;
          taken = 1'b1;
        end else begin
          split_number_dot();
        end
      end
      if (!taken) begin
        case (scan_md)
          sts_pkg::MSlash: begin
            if (c == "/") begin
              scan_md = sts_pkg::MLine;
              taken = 1'b1;
            end else if (c == "*") begin
              scan_md = sts_pkg::MBlock;
              taken = 1'b1;
            end else begin
              push_current(sts_pkg::KSlash);
              scan_md = sts_pkg::MIdle;
            end
          end
          sts_pkg::MLine: begin
            if (c == 8'h0A) scan_md = sts_pkg::MIdle;
            taken = 1'b1;
          end
          sts_pkg::MBlock: begin
            if (c == "*") scan_md = sts_pkg::MBstar;
            taken = 1'b1;
          end
          sts_pkg::MBstar: begin
            if (c == "/") scan_md = sts_pkg::MIdle;
            else if (c != "*") scan_md = sts_pkg::MBlock;
            taken = 1'b1;
          end
          sts_pkg::MIdent: begin
            if (alpha_c(c) || digit_c(c) || c == "_") begin
              if (word_cnt < 7) word_buf[word_cnt] = c;
              word_cnt = sat_inc(word_cnt, 1);
              taken = 1'b1;
            end else begin
              push_current(word_kind());
              scan_md = sts_pkg::MIdle;
            end
          end
          sts_pkg::MInt: begin
            if (digit_c(c)) begin
              word_cnt = sat_inc(word_cnt, 1);
              taken = 1'b1;
            end else if (c == ".") begin
              scan_md = sts_pkg::MDot;
              taken = 1'b1;
            end else begin
              push_current(sts_pkg::KInt);
              scan_md = sts_pkg::MIdle;
            end
          end
          sts_pkg::MFrac: begin
            if (digit_c(c)) begin
              word_cnt = sat_inc(word_cnt, 1);
              taken = 1'b1;
            end else if (c == "f") begin
              word_cnt = sat_inc(word_cnt, 1);
              push_current(sts_pkg::KFloat);
              scan_md = sts_pkg::MIdle;
              taken = 1'b1;
            end else begin
              push_current(sts_pkg::KDouble);
              scan_md = sts_pkg::MIdle;
            end
          end
          sts_pkg::MStr: begin
            word_cnt = sat_inc(word_cnt, 1);
            if (c == "\\") begin
              scan_md = sts_pkg::MEsc;
            end else if (c == "\"") begin
              push_current(sts_pkg::KStrLit);
              scan_md = sts_pkg::MIdle;
            end
            taken = 1'b1;
          end
          sts_pkg::MEsc: begin
            word_cnt = sat_inc(word_cnt, 1);
            scan_md = sts_pkg::MStr;
            taken = 1'b1;
          end
          sts_pkg::MOp: begin
            k = pair_kind(pend_byte, c);
            if (k != sts_pkg::KNone) begin
              word_cnt = 2;
              push_current(k);
              taken = 1'b1;
            end else begin
              k = single_kind(pend_byte);
              push_current(k != sts_pkg::KNone ? k : sts_pkg::KError);
            end
            scan_md = sts_pkg::MIdle;
          end
          default: ;
        endcase
      end
      if (!taken) begin_token(c);
      byte_off = sat_inc(byte_off, 1);
      if (c == 8'h0A) begin
        cur_line = sat_inc(cur_line, 1);
        cur_col = 1;
      end else begin
        cur_col = sat_inc(cur_col, 1);
      end
    end
    if (emitted > 0) token_q[token_q.size()-1].last = 1'b1;
  endfunction

  task automatic send_beat(bit op, logic [7:0] b);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    byte_in_i <= b;
    burst_left--;
    do @(posedge clk_i); while (!in_ready_o);
    predict_tokens(op, b);
    bytes_sent++;
  endtask

  task automatic send_source(string s, bit with_end = 1'b1);
    for (int i = 0; i < s.len(); i++) send_beat(OpByte, s[i]);
    if (with_end) begin
      send_beat(OpEnd, 8'($urandom_range(0, 255)));
      sources_sent++;
    end
  endtask

  task automatic test_words_and_operators();
    send_source("fn struct trait impl macro use const let mut pub if else for in match");
    send_source("return try catch finally true false None int float double bool string");
    send_source("finallyx _a9 Zz()\n{}[],.:;+-*/%!&|<>=$");
    send_source("->=>::..==!=<=>=&&||");
    send_source("x<");
  endtask

  task automatic test_numbers();
    send_source("12.5 3.25f 7.f 9..2 42. 0.0f1 8");
    send_source("5.");
    send_source("6.75");
  endtask

  task automatic test_comments_and_strings();
    send_source("a// note\nb/* x * / **/c /*/ d */ e /");
    send_source("/* open");
    send_source("\"s\\\"q\" \"t\\\\\"");
    send_source("\"open");
    send_source("\"tail\\");
  endtask

  task automatic test_unknown_bytes();
    send_source("ab #cd ef");
    send_source($sformatf("x %cy", 8'hFF));
    send_source("");
    send_beat(OpByte, "k");
    send_beat(OpByte, 8'd0);
    sources_sent++;
  endtask

  function automatic string random_fragment();
    string s;
    int n;
    s = "";
    case ($urandom_range(0, 11))
      0, 1: begin
        if ($urandom_range(0, 2) == 0) begin
          s = kw_names[$urandom_range(0, 26)];
        end else begin
          n = $urandom_range(1, 9);
          for (int i = 0; i < n; i++)
            s = $sformatf("%s%c", s, (i > 0 && $urandom_range(0, 3) == 0) ?
                          8'h30 + $urandom_range(0, 9) : 8'h61 + $urandom_range(0, 25));
        end
      end
      2: s = $sformatf("%0d", $urandom_range(0, 99999));
      3: s = $sformatf("%0d.%0d%s", $urandom_range(0, 999), $urandom_range(0, 99),
                       $urandom_range(0, 1) ? "f" : "");
      4: s = $sformatf("%0d.%s", $urandom_range(0, 99), $urandom_range(0, 1) ? "." : "");
      5: s = $urandom_range(0, 1) ? "\"ab\\\"c\"" : $sformatf("\"%0d x\"", $urandom_range(0, 9));
      6, 7: s = frag_ops[$urandom_range(0, 15)];
      8: s = $urandom_range(0, 1) ? "// c\n" : "/* k **/";
      9: s = $urandom_range(0, 1) ? "\n" : "\t";
      10: s = two_ops[$urandom_range(0, 9)];
      default: s = " ";
    endcase
    if ($urandom_range(0, 1)) s = {s, " "};
    return s;
  endfunction

  task automatic test_random_sources();
    string s;
    int goal;
    goal = bytes_sent + 40;
    while (bytes_sent < goal) begin
      s = "";
      repeat ($urandom_range(3, 15)) s = {s, random_fragment()};
      case ($urandom_range(0, 9))
        0: s = $sformatf("%s%c", s, $urandom_range(1, 255));
        1: s = $sformatf("%s%s", s, $urandom_range(0, 1) ? "\"ab" : "\"q\\");
        default: ;
      endcase
      send_source(s);
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (($time / 2000) % 3 == 2) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk_i) begin
    token_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{kind: kind_o, off: start_offset_o, len: token_length_o, line: line_no_o,
              col: col_no_o, last: last_o};
      if (token_q.size() == 0) begin
        $display("%0t: token with none expected: kind %0d off %0d", $time, kind_o,
                 start_offset_o);
        errors++;
      end else begin
        want = token_q.pop_front();
        tokens_checked++;
        if (got.kind !== want.kind || got.off !== want.off || got.len !== want.len ||
            got.line !== want.line || got.col !== want.col || got.last !== want.last) begin
          $display("%0t: expected kind %0d off %0d len %0d line %0d col %0d last %0d",
                   $time, want.kind, want.off, want.len, want.line, want.col, want.last);
          $display("%0t: actual   kind %0d off %0d len %0d line %0d col %0d last %0d",
                   $time, got.kind, got.off, got.len, got.line, got.col, got.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("source_token_scanner test failed");
        $finish;
      end
    end
  end

  initial begin
    clear_scanner();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_words_and_operators();
    test_numbers();
    test_comments_and_strings();
    test_unknown_bytes();
    test_random_sources();
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Scanned %0d sources of %0d bytes; %0d tokens checked.", sources_sent,
             bytes_sent, tokens_checked);
    if (errors == 0 && token_q.size() == 0) begin
      $display("source_token_scanner test passed");
    end else begin
      $display("source_token_scanner test failed");
    end
    $finish;
  end

endmodule
